FILE: hw/rtl/apts_pkg.sv
// ----------------------------------------------------------------------------
// apts_pkg: shared definitions for the associative page table
// Opcodes, sequencer states, the command broadcast to the entry cells and
// the default sizes handed to the top level.
// ----------------------------------------------------------------------------
package apts_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 16;
  localparam int PAGE_BITS_DEFAULT   = 20;
  localparam int FRAME_BITS_DEFAULT  = 16;
  localparam int STAMP_BITS          = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP    = 2'd0,
    OP_FIND_FREE = 2'd1,
    OP_INSTALL   = 2'd2,
    OP_TOUCH     = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  // Command seen by every cell; commit marks the cycle in which the result
  // is registered and the addressed cell takes its write.
  typedef struct packed {
    op_t  op;
    logic commit;
  } cmd_t;

endpackage

FILE: hw/rtl/apts_cell.sv
// ----------------------------------------------------------------------------
// apts_cell: one table entry with its link in the priority chain
// Holds valid, page, frame and both stamps. Decides whether it is selected
// by the current command and passes the first selected entry downstream.
// ----------------------------------------------------------------------------
module apts_cell #(
  parameter int PAGE_BITS  = apts_pkg::PAGE_BITS_DEFAULT,
  parameter int FRAME_BITS = apts_pkg::FRAME_BITS_DEFAULT,
  parameter int IDX_BITS   = 4,
  parameter int CELL_INDEX = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            used,
  input  apts_pkg::cmd_t                  cmd,
  input  logic [PAGE_BITS-1:0]            req_page,
  input  logic [FRAME_BITS-1:0]           req_frame,
  input  logic [IDX_BITS-1:0]             req_idx,
  input  logic [apts_pkg::STAMP_BITS-1:0] fifo_cnt,
  input  logic [apts_pkg::STAMP_BITS-1:0] lru_cnt,
  input  logic                            up_found,
  input  logic [IDX_BITS-1:0]             up_index,
  input  logic [FRAME_BITS-1:0]           up_frame,
  input  logic [apts_pkg::STAMP_BITS-1:0] up_fifo,
  input  logic [apts_pkg::STAMP_BITS-1:0] up_lru,
  output logic                            dn_found,
  output logic [IDX_BITS-1:0]             dn_index,
  output logic [FRAME_BITS-1:0]           dn_frame,
  output logic [apts_pkg::STAMP_BITS-1:0] dn_fifo,
  output logic [apts_pkg::STAMP_BITS-1:0] dn_lru
);

  logic                            valid;
  logic [PAGE_BITS-1:0]            page;
  logic [FRAME_BITS-1:0]           frame;
  logic [apts_pkg::STAMP_BITS-1:0] fifo;
  logic [apts_pkg::STAMP_BITS-1:0] lru;
  logic                            addressed;
  logic                            sel;

  assign addressed = used && (req_idx == IDX_BITS'(CELL_INDEX));

  always_comb begin
    unique case (cmd.op)
      apts_pkg::OP_LOOKUP:    sel = used && valid && (page == req_page);
      apts_pkg::OP_FIND_FREE: sel = used && !valid;
      apts_pkg::OP_INSTALL:   sel = addressed;
      apts_pkg::OP_TOUCH:     sel = addressed;
      default:                sel = 1'b0;
    endcase
  end

  // An upstream selection wins; an entry that is not valid shows no FIFO stamp.
  always_comb begin
    if (up_found) begin
      dn_found = 1'b1;
      dn_index = up_index;
      dn_frame = up_frame;
      dn_fifo  = up_fifo;
      dn_lru   = up_lru;
    end else if (sel) begin
      dn_found = 1'b1;
      dn_index = IDX_BITS'(CELL_INDEX);
      dn_frame = frame;
      dn_fifo  = valid ? fifo : '0;
      dn_lru   = lru;
    end else begin
      dn_found = 1'b0;
      dn_index = '0;
      dn_frame = '0;
      dn_fifo  = '0;
      dn_lru   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.commit && addressed && cmd.op == apts_pkg::OP_INSTALL) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && addressed) begin
      if (cmd.op == apts_pkg::OP_INSTALL) begin
        page  <= req_page;
        frame <= req_frame;
        fifo  <= fifo_cnt;
        lru   <= lru_cnt;
      end else if (cmd.op == apts_pkg::OP_TOUCH) begin
        lru   <= lru_cnt;
      end
    end
  end

endmodule

FILE: hw/rtl/assoc_page_table_stamps.sv
// ----------------------------------------------------------------------------
// assoc_page_table_stamps: fully associative page table with age stamps
// A row of entry cells searched in parallel, with a priority chain picking
// the lowest selected entry, a two-state sequencer and a result register.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | opcode, virtual_page, physical_frame,
//           |                      | entry_index
//  output   | out_valid / out_ready| hit, frame_out, free_found, free_index,
//           |                      | fifo_stamp, lru_stamp
//  config   | cfg_we               | cfg_wdata (entries_in_use)
//
// A transaction registers the request while idle; in the evaluation state the
// cells compare and the priority chain settles into the result register.
// A new request is taken while a result still waits; the evaluation cycle
// holds, with no write, until the result register is free.
// Reset clears the valid bits, both counters and the sequencer, and sets
// entries_in_use to MAX_ENTRIES.
// ----------------------------------------------------------------------------
module assoc_page_table_stamps #(
  parameter int MAX_ENTRIES = apts_pkg::MAX_ENTRIES_DEFAULT,
  parameter int PAGE_BITS   = apts_pkg::PAGE_BITS_DEFAULT,
  parameter int FRAME_BITS  = apts_pkg::FRAME_BITS_DEFAULT,
  localparam int IDX_BITS   = $clog2(MAX_ENTRIES),
  localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [PAGE_BITS-1:0]            virtual_page,
  input  logic [FRAME_BITS-1:0]           physical_frame,
  input  logic [IDX_BITS-1:0]             entry_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [FRAME_BITS-1:0]           frame_out,
  output logic                            free_found,
  output logic [IDX_BITS-1:0]             free_index,
  output logic [apts_pkg::STAMP_BITS-1:0] fifo_stamp,
  output logic [apts_pkg::STAMP_BITS-1:0] lru_stamp,
  input  logic                            cfg_we,
  input  logic [CNT_BITS-1:0]             cfg_wdata
);

  apts_pkg::state_t                state, state_next;
  apts_pkg::op_t                   req_op;
  logic [PAGE_BITS-1:0]            req_page;
  logic [FRAME_BITS-1:0]           req_frame;
  logic [IDX_BITS-1:0]             req_idx;
  logic [CNT_BITS-1:0]             entries_in_use;
  logic [CNT_BITS-1:0]             eff_count;
  logic [apts_pkg::STAMP_BITS-1:0] fifo_counter;
  logic [apts_pkg::STAMP_BITS-1:0] lru_counter;
  logic                            accept;
  logic                            commit;
  apts_pkg::cmd_t                  cmd;

  logic                            link_found [MAX_ENTRIES+1];
  logic [IDX_BITS-1:0]             link_index [MAX_ENTRIES+1];
  logic [FRAME_BITS-1:0]           link_frame [MAX_ENTRIES+1];
  logic [apts_pkg::STAMP_BITS-1:0] link_fifo  [MAX_ENTRIES+1];
  logic [apts_pkg::STAMP_BITS-1:0] link_lru   [MAX_ENTRIES+1];

  logic                            hit_next;
  logic [FRAME_BITS-1:0]           frame_next;
  logic                            free_found_next;
  logic [IDX_BITS-1:0]             free_index_next;
  logic [apts_pkg::STAMP_BITS-1:0] fifo_next;
  logic [apts_pkg::STAMP_BITS-1:0] lru_next;
  logic                            addr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CNT_BITS'(MAX_ENTRIES);
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // A count of zero acts as one; counts beyond the table act as the full table.
  always_comb begin
    priority if (entries_in_use == '0) begin
      eff_count = CNT_BITS'(1);
    end else if (entries_in_use > CNT_BITS'(MAX_ENTRIES)) begin
      eff_count = CNT_BITS'(MAX_ENTRIES);
    end else begin
      eff_count = entries_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      apts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = apts_pkg::ST_EVAL;
        end
      end
      apts_pkg::ST_EVAL: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = apts_pkg::ST_IDLE;
        end
      end
      default: state_next = apts_pkg::ST_IDLE;
    endcase
  end

  assign accept     = in_valid && in_ready;
  assign cmd.op     = req_op;
  assign cmd.commit = commit;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= apts_pkg::op_t'(opcode);
      req_page  <= virtual_page;
      req_frame <= physical_frame;
      req_idx   <= entry_index;
    end
  end

  assign link_found[0] = 1'b0;
  assign link_index[0] = '0;
  assign link_frame[0] = '0;
  assign link_fifo[0]  = '0;
  assign link_lru[0]   = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    apts_cell #(
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS),
      .IDX_BITS   (IDX_BITS),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .used      (CNT_BITS'(i) < eff_count),
      .cmd       (cmd),
      .req_page  (req_page),
      .req_frame (req_frame),
      .req_idx   (req_idx),
      .fifo_cnt  (fifo_counter),
      .lru_cnt   (lru_counter),
      .up_found  (link_found[i]),
      .up_index  (link_index[i]),
      .up_frame  (link_frame[i]),
      .up_fifo   (link_fifo[i]),
      .up_lru    (link_lru[i]),
      .dn_found  (link_found[i+1]),
      .dn_index  (link_index[i+1]),
      .dn_frame  (link_frame[i+1]),
      .dn_fifo   (link_fifo[i+1]),
      .dn_lru    (link_lru[i+1])
    );
  end

  // For install and touch the chain end reports whether the index is in use.
  assign addr_ok = link_found[MAX_ENTRIES];

  always_comb begin
    hit_next        = 1'b0;
    frame_next      = '0;
    free_found_next = 1'b0;
    free_index_next = '0;
    fifo_next       = '0;
    lru_next        = '0;
    unique case (req_op)
      apts_pkg::OP_LOOKUP: begin
        hit_next   = addr_ok;
        frame_next = link_frame[MAX_ENTRIES];
        fifo_next  = link_fifo[MAX_ENTRIES];
        lru_next   = link_lru[MAX_ENTRIES];
      end
      apts_pkg::OP_FIND_FREE: begin
        free_found_next = addr_ok;
        free_index_next = link_index[MAX_ENTRIES];
      end
      apts_pkg::OP_INSTALL: begin
        if (addr_ok) begin
          fifo_next = fifo_counter;
          lru_next  = lru_counter;
        end
      end
      apts_pkg::OP_TOUCH: begin
        if (addr_ok) begin
          fifo_next = link_fifo[MAX_ENTRIES];
          lru_next  = lru_counter;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_counter <= '0;
      lru_counter  <= '0;
    end else if (commit && addr_ok) begin
      if (req_op == apts_pkg::OP_INSTALL) begin
        fifo_counter <= fifo_counter + 1'b1;
        lru_counter  <= lru_counter + 1'b1;
      end else if (req_op == apts_pkg::OP_TOUCH) begin
        lru_counter  <= lru_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit        <= hit_next;
      frame_out  <= frame_next;
      free_found <= free_found_next;
      free_index <= free_index_next;
      fifo_stamp <= fifo_next;
      lru_stamp  <= lru_next;
    end
  end

endmodule
